// ===== rtl/core/spiral_order_matrix_scan_defines.svh =====
// Assertion macros used by the spiral scan walker RTL.
`ifndef SPIRAL_ORDER_MATRIX_SCAN_DEFINES_SVH
`define SPIRAL_ORDER_MATRIX_SCAN_DEFINES_SVH

// Plain property checked on every rising clock edge outside reset.
`define SOMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SOMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SOMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/soms_pkg.sv =====
// Types, constants and helpers shared by the spiral scan modules.
package soms_pkg;

  localparam int ELEM_W    = 32;
  localparam int CNT_W     = 4;
  localparam int POS_W     = 3;
  localparam int TOT_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    HEAD_RIGHT,
    HEAD_DOWN,
    HEAD_LEFT,
    HEAD_UP
  } heading_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  // One loaded matrix waiting for emission
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic [TOT_W-1:0] total;
  } job_t;

  // Buffer handed back to the loader
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // Zero counts as one, anything above the limit saturates
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== rtl/core/soms_front.sv =====
// Loader: takes elements, fills a matrix buffer and posts finished matrices.
module soms_front import soms_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int AW       = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CNT_W-1:0]         row_count,
  input  logic [CNT_W-1:0]         column_count,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] element_value,
  output logic                     wr_en,
  output logic [AW:0]              wr_addr,
  output logic [ELEM_W-1:0]        wr_data,
  output logic                     job_push,
  output job_t                     job,
  input  release_t                 rel
);

  logic [TOT_W-1:0]   loaded, loaded_next, loaded_inc;
  logic               wr_bank, wr_bank_next;
  logic [1:0]         bank_busy, bank_busy_next;
  logic [CNT_W-1:0]   rows, cols;
  logic [2*CNT_W-1:0] total_full;
  logic [TOT_W-1:0]   total;
  logic               accept, matrix_done;

  // Sizes as seen by this element
  assign rows       = clamp_count(row_count, CNT_W'(MAX_ROWS));
  assign cols       = clamp_count(column_count, CNT_W'(MAX_COLS));
  assign total_full = rows * cols;
  assign total      = total_full[TOT_W-1:0];

  // Hold off while the fill buffer still awaits emission
  assign in_stall    = bank_busy[wr_bank];
  assign accept      = in_valid && !in_stall;
  assign loaded_inc  = loaded + TOT_W'(1);
  assign matrix_done = accept && (loaded_inc >= total);

  assign wr_en   = accept;
  assign wr_addr = {wr_bank, loaded[AW-1:0]};
  assign wr_data = element_value;

  assign job_push = matrix_done;
  assign job      = '{bank: wr_bank, rows: rows, cols: cols, total: total};

  // Fill count, buffer select and ownership
  always_comb begin
    loaded_next    = loaded;
    wr_bank_next   = wr_bank;
    bank_busy_next = bank_busy;
    if (rel.valid) bank_busy_next[rel.bank] = 1'b0;
    if (matrix_done) begin
      bank_busy_next[wr_bank] = 1'b1;
      wr_bank_next            = ~wr_bank;
      loaded_next             = '0;
    end else if (accept) begin
      loaded_next = loaded_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      wr_bank   <= 1'b0;
      bank_busy <= '0;
    end else begin
      loaded    <= loaded_next;
      wr_bank   <= wr_bank_next;
      bank_busy <= bank_busy_next;
    end
  end

endmodule

// ===== rtl/core/soms_queue.sv =====
// Two-entry queue of loaded matrices between loader and walker.
module soms_queue import soms_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic avail,
  output job_t head
);

  job_t       slot [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign avail = (fill != 2'd0);
  assign head  = slot[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_job;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/soms_back.sv =====
// Walker: holds the element buffers and emits each matrix in spiral order.
`include "spiral_order_matrix_scan_defines.svh"
module soms_back import soms_pkg::*; #(
  parameter int AW = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [AW:0]              wr_addr,
  input  logic [ELEM_W-1:0]        wr_data,
  input  logic                     job_avail,
  input  job_t                     job,
  output logic                     job_pop,
  output release_t                 rel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_value,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic                     last_of_run
);

  localparam int MEM_DEPTH = 2 ** (AW + 1);

  logic [ELEM_W-1:0] mem [MEM_DEPTH];
  logic [ELEM_W-1:0] rd_data;
  logic [AW:0]       rd_addr;

  back_state_t      state, state_next;
  job_t             cur, cur_next;
  heading_t         heading, heading_next;
  logic [POS_W-1:0] row, row_next, col, col_next;
  logic [POS_W-1:0] top, top_next, bot, bot_next;
  logic [POS_W-1:0] lft, lft_next, rgt, rgt_next;
  logic [TOT_W-1:0] emit_cnt, emit_cnt_next;

  heading_t         step_head;
  logic [POS_W-1:0] step_row, step_col, step_top, step_bot, step_lft, step_rgt;

  logic [POS_W-1:0] rd_row, rd_col;
  logic [CNT_W-1:0] rd_cols;
  logic             rd_bank;
  logic [TOT_W-1:0] lin;
  logic [CNT_W-1:0] rows_m1, cols_m1;
  logic             fire, is_last;

  // Element buffers: one write port from the loader, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign out_valid   = (state == ST_RUN);
  assign fire        = out_valid && !out_stall;
  assign is_last     = (emit_cnt == cur.total - TOT_W'(1));
  assign out_value   = $signed(rd_data);
  assign out_row     = row;
  assign out_col     = col;
  assign last_of_run = is_last;

  assign rows_m1 = job.rows - CNT_W'(1);
  assign cols_m1 = job.cols - CNT_W'(1);

  // One spiral step: advance, or turn clockwise and pull in the passed edge
  always_comb begin
    step_head = heading;
    step_row  = row;
    step_col  = col;
    step_top  = top;
    step_bot  = bot;
    step_lft  = lft;
    step_rgt  = rgt;
    case (heading)
      HEAD_RIGHT: begin
        if (col != rgt) step_col = col + POS_W'(1);
        else begin
          step_head = HEAD_DOWN;
          step_top  = top + POS_W'(1);
          step_row  = row + POS_W'(1);
        end
      end
      HEAD_DOWN: begin
        if (row != bot) step_row = row + POS_W'(1);
        else begin
          step_head = HEAD_LEFT;
          step_rgt  = rgt - POS_W'(1);
          step_col  = col - POS_W'(1);
        end
      end
      HEAD_LEFT: begin
        if (col != lft) step_col = col - POS_W'(1);
        else begin
          step_head = HEAD_UP;
          step_bot  = bot - POS_W'(1);
          step_row  = row - POS_W'(1);
        end
      end
      HEAD_UP: begin
        if (row != top) step_row = row - POS_W'(1);
        else begin
          step_head = HEAD_RIGHT;
          step_lft  = lft + POS_W'(1);
          step_col  = col + POS_W'(1);
        end
      end
      default: step_head = HEAD_RIGHT;
    endcase
  end

  // Sequencer: start a matrix, then one element per transaction
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    heading_next  = heading;
    row_next      = row;
    col_next      = col;
    top_next      = top;
    bot_next      = bot;
    lft_next      = lft;
    rgt_next      = rgt;
    emit_cnt_next = emit_cnt;
    job_pop       = 1'b0;
    rel           = '0;
    rd_row        = row;
    rd_col        = col;
    rd_cols       = cur.cols;
    rd_bank       = cur.bank;
    case (state)
      ST_IDLE: begin
        if (job_avail) begin
          job_pop       = 1'b1;
          cur_next      = job;
          heading_next  = HEAD_RIGHT;
          row_next      = '0;
          col_next      = '0;
          top_next      = '0;
          lft_next      = '0;
          bot_next      = rows_m1[POS_W-1:0];
          rgt_next      = cols_m1[POS_W-1:0];
          emit_cnt_next = '0;
          rd_row        = '0;
          rd_col        = '0;
          rd_cols       = job.cols;
          rd_bank       = job.bank;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fire) begin
          if (is_last) begin
            rel.valid  = 1'b1;
            rel.bank   = cur.bank;
            state_next = ST_IDLE;
          end else begin
            heading_next  = step_head;
            row_next      = step_row;
            col_next      = step_col;
            top_next      = step_top;
            bot_next      = step_bot;
            lft_next      = step_lft;
            rgt_next      = step_rgt;
            emit_cnt_next = emit_cnt + TOT_W'(1);
            rd_row        = step_row;
            rd_col        = step_col;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Row-major address of the cell the output register shows next
  assign lin     = TOT_W'(rd_row) * TOT_W'(rd_cols) + TOT_W'(rd_col);
  assign rd_addr = {rd_bank, lin[AW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    heading  <= heading_next;
    row      <= row_next;
    col      <= col_next;
    top      <= top_next;
    bot      <= bot_next;
    lft      <= lft_next;
    rgt      <= rgt_next;
    emit_cnt <= emit_cnt_next;
  end

  `SOMS_ASSERT_IMP(a_pos_in_matrix, out_valid, ({1'b0, row} < cur.rows) && ({1'b0, col} < cur.cols), "spiral cursor left the matrix")
  `SOMS_ASSERT_IMP(a_count_in_range, out_valid, emit_cnt < cur.total, "emitted more elements than the matrix holds")
  `SOMS_ASSERT_NXT(a_last_ends_run, fire && is_last, !out_valid || ($past(job_avail) && $past(rel.valid)) == 1'b0, "transaction after final element without a new matrix start")

endmodule

// ===== rtl/core/spiral_order_matrix_scan.sv =====
// Spiral scan top level: configuration registers, loader, queue and walker.
// Elements load in row-major order at one per cycle while in_stall is low
// into one of two matrix buffers (each MAX_ROWS x MAX_COLS words, rounded
// up to a power of two). Once row_count x column_count elements are in, the
// matrix is posted to a two-entry queue and the walker emits it in clockwise
// spiral order, one element per cycle while out_stall is low after a start
// step in the idle state, each with its row, column and a final-element flag.
// Loading of the next matrix overlaps emission of the previous one; the
// input stalls only while both buffers hold matrices not yet fully emitted.
// Write the size registers only while no matrix is partly loaded; a matrix
// that is already loaded keeps the sizes it was loaded with.
module spiral_order_matrix_scan import soms_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_value,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic                     last_of_run
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0]  row_count, column_count;
  logic              wr_en;
  logic [AW:0]       wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic              job_push, job_pop, job_avail;
  job_t              push_job, head_job;
  release_t          rel;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CNT_W'(8);
      column_count <= CNT_W'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROWS: row_count    <= cfg_data;
        CFG_COLS: column_count <= cfg_data;
        default:  ;
      endcase
    end
  end

  soms_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .AW      (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .row_count    (row_count),
    .column_count (column_count),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element_value(element_value),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .job_push     (job_push),
    .job          (push_job),
    .rel          (rel)
  );

  soms_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .push_job(push_job),
    .pop     (job_pop),
    .avail   (job_avail),
    .head    (head_job)
  );

  soms_back #(
    .AW(AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .job_avail  (job_avail),
    .job        (head_job),
    .job_pop    (job_pop),
    .rel        (rel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .last_of_run(last_of_run)
  );

endmodule

// ===== tb/tb_spiral_order_matrix_scan.sv =====
`timescale 1ns / 100ps
// Testbench for the spiral matrix scan: directed shapes, count limits and random traffic.
module tb_spiral_order_matrix_scan;
  import soms_pkg::*;

  localparam int DIM_LIMIT     = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // One emitted matrix element with its position
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
  } spiral_entry_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_ROWS;
  logic [CNT_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ELEM_W-1:0] out_value;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     last_of_run;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned elements_sent = 0;
  int unsigned fail_count = 0;

  // Predictor state: register copies, the matrix being loaded, pending results
  logic [CNT_W-1:0]         shadow_rows = 4'd8;
  logic [CNT_W-1:0]         shadow_cols = 4'd8;
  logic signed [ELEM_W-1:0] matrix_copy [DIM_LIMIT*DIM_LIMIT];
  int unsigned              filled = 0;
  spiral_entry_t            spiral_expect [$];

  spiral_order_matrix_scan dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Zero means one, anything past the limit saturates
  function automatic int unsigned effective_count(input logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  // Walk the loaded matrix clockwise from the top-left corner
  function automatic void queue_spiral(input int unsigned rows, input int unsigned cols);
    logic [DIM_LIMIT*DIM_LIMIT-1:0] seen;
    int unsigned   r, c, nr, nc, total, k, turns;
    heading_t      hd;
    logic          moved;
    spiral_entry_t entry;
    seen  = '0;
    r     = 0;
    c     = 0;
    hd    = HEAD_RIGHT;
    total = rows * cols;
    for (k = 0; k < total; k++) begin
      seen[r*cols+c] = 1'b1;
      entry.value = matrix_copy[r*cols+c];
      entry.row   = POS_W'(r);
      entry.col   = POS_W'(c);
      entry.last  = (k + 1 == total);
      spiral_expect = {spiral_expect, entry};
      if (k + 1 == total) break;
      moved = 1'b0;
      for (turns = 0; turns < 4 && !moved; turns++) begin
        nr    = r;
        nc    = c;
        moved = 1'b1;
        case (hd)
          HEAD_RIGHT: if (c + 1 >= cols) moved = 1'b0; else nc = c + 1;
          HEAD_DOWN:  if (r + 1 >= rows) moved = 1'b0; else nr = r + 1;
          HEAD_LEFT:  if (c == 0) moved = 1'b0; else nc = c - 1;
          default:    if (r == 0) moved = 1'b0; else nr = r - 1;
        endcase
        if (moved && seen[nr*cols+nc]) moved = 1'b0;
        if (moved) begin
          r = nr;
          c = nc;
        end else begin
          hd = heading_t'(hd + 2'd1);
        end
      end
      if (!moved) break;
    end
  endfunction

  // Record one accepted element; the last one of the matrix releases the spiral
  function automatic void accept_element(input logic signed [ELEM_W-1:0] v);
    int unsigned rows, cols;
    rows = effective_count(shadow_rows);
    cols = effective_count(shadow_cols);
    matrix_copy[filled % (DIM_LIMIT*DIM_LIMIT)] = v;
    filled++;
    if (filled >= rows * cols) begin
      queue_spiral(rows, cols);
      filled = 0;
    end
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stall and in-order compare
  always @(posedge clk) begin : result_check
    spiral_entry_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (spiral_expect.size() == 0) begin
          log_failure($sformatf("unexpected result: value %0d row %0d col %0d last %0b",
                                out_value, out_row, out_col, last_of_run));
        end else begin
          want = spiral_expect.pop_front();
          if (out_value !== want.value || out_row !== want.row ||
              out_col !== want.col || last_of_run !== want.last)
            log_failure($sformatf(
              "mismatch: expected value %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
              want.value, want.row, want.col, want.last,
              out_value, out_row, out_col, last_of_run));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one element, with an optional random gap; valid stays high afterwards
  task automatic send_element(input logic signed [ELEM_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accept_element(v);
    elements_sent++;
  endtask

  task automatic wait_until_drained();
    while (spiral_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block idle
  task automatic set_shape(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
    in_valid <= 1'b0;
    wait_until_drained();
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_write   <= 1'b0;
    shadow_rows = rows;
    shadow_cols = cols;
  endtask

  task automatic send_matrix();
    int unsigned total;
    total = effective_count(shadow_rows) * effective_count(shadow_cols);
    repeat (total) send_element(pick_element());
  endtask

  // 1x1 matrices, the second one through zero counts
  task automatic test_single_cell();
    set_shape(4'd1, 4'd1);
    send_element(32'sh7fff_ffff);
    set_shape(4'd0, 4'd0);
    send_element(32'sh8000_0000);
  endtask

  // Counts above the limit saturate to a full row or column
  task automatic test_saturated_counts();
    set_shape(4'd1, 4'd15);
    send_element(-32'sd1);
    send_element('0);
    repeat (6) send_element($urandom);
    set_shape(4'd15, 4'd1);
    repeat (8) send_element($urandom);
  endtask

  // 3x3 walk: every heading and the inner cell
  task automatic test_square_walk();
    set_shape(4'd3, 4'd3);
    repeat (9) send_element($urandom);
  endtask

  // Random shapes, mostly small, one to three matrices back to back per shape
  task automatic test_random_shapes(input int unsigned budget);
    int unsigned start, n;
    logic [CNT_W-1:0] rows, cols;
    start = elements_sent;
    while (elements_sent - start < budget) begin
      if ($urandom_range(4) == 0) begin
        rows = CNT_W'($urandom_range(15));
        cols = CNT_W'($urandom_range(15));
      end else begin
        rows = CNT_W'($urandom_range(1, 4));
        cols = CNT_W'($urandom_range(1, 4));
      end
      set_shape(rows, cols);
      n = $urandom_range(1, 3);
      repeat (n) send_matrix();
    end
  endtask

  // Sender holds off mid-matrix until the previous spiral is out, then a full 8x8
  task automatic test_pause_for_drain();
    set_shape(4'd7, 4'd5);
    send_matrix();
    repeat (17) send_element(pick_element());
    in_valid <= 1'b0;
    do @(posedge clk); while (spiral_expect.size() != 0);
    repeat (18) send_element(pick_element());
    set_shape(4'd8, 4'd8);
    send_matrix();
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 55;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_single_cell();
    test_saturated_counts();
    test_square_walk();
    test_random_shapes(20);

    send_idle_pct = 55;
    recv_idle_pct = 16;
    test_random_shapes(20);
    test_pause_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_shapes(20);

    in_valid <= 1'b0;
    wait_until_drained();
    if (spiral_expect.size() != 0)
      log_failure($sformatf("%0d results never arrived", spiral_expect.size()));
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/soms_pkg.sv
rtl/core/soms_front.sv
rtl/core/soms_queue.sv
rtl/core/soms_back.sv
rtl/core/spiral_order_matrix_scan.sv
tb/tb_spiral_order_matrix_scan.sv
